FILE: src/bpab_pkg.sv
// Shared types, constants and register indexes of the bitmap pixel alpha blender.
package bpab_pkg;

    localparam logic INVERT_BRIGHTNESS = 1'b0;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_FORMAT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_LAST = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BYTE_ORDER = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERT_ALPHA = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_LAYER = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BACKGROUND = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_TRANSPARENCY = 3'd6;

    localparam int QDEPTH = 4;
    localparam int QADDR_W = $clog2(QDEPTH);

    typedef struct packed {
        logic        pixel_format;
        logic        alpha_last;
        logic        byte_order;
        logic        invert_alpha;
        logic        first_layer;
        logic [23:0] background_color;
        logic [7:0]  transparency;
    } cfg_t;

    // One classified pixel with its blend weights.
    typedef struct packed {
        logic [8:0]  wc;
        logic [8:0]  wb;
        logic [23:0] color;
        logic [23:0] back;
    } job_t;

endpackage

FILE: src/bpab_front.sv
// Front part: accepts a word, unpacks the pixel, derives the blend weights.
module bpab_front
    import bpab_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,
    output logic        push,
    output job_t        push_job,
    input  logic        q_ready
);

    logic        valid_reg;
    logic [23:0] color_reg;
    logic [23:0] back_reg;
    logic [15:0] prod_reg;

    logic [7:0]  b0;
    logic [7:0]  b1;
    logic [7:0]  b2;
    logic [7:0]  b3;
    logic [7:0]  alpha;
    logic [7:0]  first_byte;
    logic [7:0]  mid_byte;
    logic [7:0]  last_byte;
    logic [23:0] color_next;
    logic [23:0] back_next;
    logic [8:0]  t;
    logic [8:0]  inv_t;
    logic [16:0] prod_full;
    logic [16:0] div_sum;
    logic [8:0]  d;
    logic        load;

    assign b0 = s_tdata[7:0];
    assign b1 = s_tdata[15:8];
    assign b2 = s_tdata[23:16];
    assign b3 = s_tdata[31:24];

    assign t = {1'b0, cfg.transparency} + {8'd0, (cfg.transparency == 8'hFF)};
    assign inv_t = 9'd256 - t;

    always_comb
    begin
        alpha = 8'd0;
        first_byte = b0;
        mid_byte = b1;
        last_byte = b2;
        if (cfg.pixel_format)
        begin
            if (cfg.alpha_last)
            begin
                alpha = b3;
            end
            else
            begin
                alpha = b0;
                first_byte = b1;
                mid_byte = b2;
                last_byte = b3;
            end
        end
        if (cfg.byte_order)
        begin
            color_next = {last_byte, mid_byte, first_byte};
        end
        else
        begin
            color_next = {first_byte, mid_byte, last_byte};
        end
        if (INVERT_BRIGHTNESS)
        begin
            color_next = ~color_next;
        end
        if (cfg.first_layer)
        begin
            back_next = cfg.background_color;
        end
        else
        begin
            back_next = s_tdata[55:32];
        end
        prod_full = {9'd0, alpha} * {8'd0, inv_t};
    end

    assign s_tready = !valid_reg || q_ready;
    assign load = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            color_reg <= color_next;
            back_reg <= back_next;
            prod_reg <= prod_full[15:0];
        end
    end

    // Division by 255 of a 16-bit value: (x + 1 + (x >> 8)) >> 8.
    assign div_sum = {1'b0, prod_reg} + 17'd1 + {9'd0, prod_reg[15:8]};
    assign d = div_sum[16:8];

    always_comb
    begin
        push_job.color = color_reg;
        push_job.back = back_reg;
        if (!cfg.pixel_format)
        begin
            push_job.wc = inv_t;
            push_job.wb = t;
        end
        else if (cfg.invert_alpha)
        begin
            push_job.wc = 9'd256 - d;
            push_job.wb = d;
        end
        else
        begin
            push_job.wc = d;
            push_job.wb = 9'd256 - d;
        end
    end

    assign push = valid_reg && q_ready;

endmodule

FILE: src/bpab_queue.sv
// Short queue of classified pixels between the front and back parts.
module bpab_queue
    import bpab_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic q_ready,
    input  logic pop,
    output logic q_valid,
    output job_t pop_job
);

    job_t               mem [QDEPTH];
    logic [QADDR_W-1:0] wr_ptr_reg;
    logic [QADDR_W-1:0] rd_ptr_reg;
    logic [QADDR_W:0]   count_reg;

    assign q_ready = (count_reg != QDEPTH[QADDR_W:0]);
    assign q_valid = (count_reg != '0);
    assign pop_job = mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

endmodule

FILE: src/bpab_back.sv
// Back part: weighted sum of source and background for each channel, output register.
module bpab_back
    import bpab_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    input  job_t        pop_job,
    output logic        pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata
);

    logic        valid_reg;
    logic [23:0] data_reg;
    logic [23:0] data_next;
    logic [17:0] sum [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sum[i] = {1'b0, {8'd0, pop_job.wc} * {9'd0, pop_job.color[8*i +: 8]}}
                   + {1'b0, {8'd0, pop_job.wb} * {9'd0, pop_job.back[8*i +: 8]}};
            data_next[8*i +: 8] = sum[i][15:8];
        end
    end

    assign pop = q_valid && (!valid_reg || m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!valid_reg || m_tready)
        begin
            valid_reg <= q_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            data_reg <= data_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata = data_reg;

endmodule

FILE: src/bitmap_pixel_alpha_blender.sv
// Top level of the bitmap pixel alpha blender: register port, front, queue and back.
// A word accepted on s_tdata passes the front register, the queue and the output
// register before it appears on m_tdata. Throughput: one word per cycle while
// m_tready stays high; a low m_tready stalls the back part and fills the queue.
// Reset (rst_n low, asynchronous) empties all stages and the queue and sets the
// registers to their defaults: first_layer is 1, all others are 0.
module bitmap_pixel_alpha_blender
    import bpab_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // src_byte0, src_byte1, src_byte2, src_byte3, dest_ch1, dest_ch2, dest_ch3
    input  logic [55:0]           s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // out_ch1, out_ch2, out_ch3
    output logic [23:0]           m_tdata
);

    cfg_t cfg_reg;
    logic push;
    job_t push_job;
    logic q_ready;
    logic pop;
    logic q_valid;
    job_t pop_job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{pixel_format: 1'b0, alpha_last: 1'b0, byte_order: 1'b0,
                         invert_alpha: 1'b0, first_layer: 1'b1,
                         background_color: 24'd0, transparency: 8'd0};
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_PIXEL_FORMAT: cfg_reg.pixel_format <= cfg_wdata[0];
                CFG_ALPHA_LAST:   cfg_reg.alpha_last <= cfg_wdata[0];
                CFG_BYTE_ORDER:   cfg_reg.byte_order <= cfg_wdata[0];
                CFG_INVERT_ALPHA: cfg_reg.invert_alpha <= cfg_wdata[0];
                CFG_FIRST_LAYER:  cfg_reg.first_layer <= cfg_wdata[0];
                CFG_BACKGROUND:   cfg_reg.background_color <= cfg_wdata[23:0];
                CFG_TRANSPARENCY: cfg_reg.transparency <= cfg_wdata[7:0];
                default:          cfg_reg <= cfg_reg;
            endcase
        end
    end

    bpab_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .push     (push),
        .push_job (push_job),
        .q_ready  (q_ready)
    );

    bpab_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .q_ready  (q_ready),
        .pop      (pop),
        .q_valid  (q_valid),
        .pop_job  (pop_job)
    );

    bpab_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .pop_job  (pop_job),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

FILE: verif/bpab_blend_checker.sv
// Checker that watches the blender's channels, predicts each blended pixel and compares it.
`timescale 1ns / 100ps

module bpab_blend_checker
    import bpab_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    // src_byte0, src_byte1, src_byte2, src_byte3, dest_ch1, dest_ch2, dest_ch3
    input  logic [55:0]           s_tdata,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    // out_ch1, out_ch2, out_ch3
    input  logic [23:0]           m_tdata,
    input  logic                  drain_done,
    output int                    fail_count,
    output int                    pending,
    output int                    checked
);

    localparam cfg_t CFG_RESET_VALUES = '{
        pixel_format: 1'b0,
        alpha_last: 1'b0,
        byte_order: 1'b0,
        invert_alpha: 1'b0,
        first_layer: 1'b1,
        background_color: 24'd0,
        transparency: 8'd0
    };
    localparam int PRINT_CAP = 60;

    cfg_t        shadow_cfg;
    logic [23:0] expected_pixels[$];
    logic [23:0] want;
    bit          drain_seen;

    function automatic logic [23:0] blend_pixel(input cfg_t c, input logic [55:0] w);
        logic [7:0]  raw [0:3];
        logic [7:0]  col [0:2];
        logic [7:0]  back [0:2];
        logic [23:0] res;
        int unsigned base;
        int unsigned alpha;
        int unsigned t;
        int unsigned inv_t;
        int unsigned d;
        int unsigned wc;
        int unsigned wb;
        for (int i = 0; i < 4; i++)
        begin
            raw[i] = w[8*i +: 8];
        end
        base = 0;
        alpha = 0;
        if (c.pixel_format)
        begin
            if (c.alpha_last)
            begin
                alpha = 32'(raw[3]);
            end
            else
            begin
                alpha = 32'(raw[0]);
                base = 1;
            end
        end
        for (int i = 0; i < 3; i++)
        begin
            if (c.byte_order)
                col[i] = raw[base + i];
            else
                col[2 - i] = raw[base + i];
        end
        for (int i = 0; i < 3; i++)
        begin
            if (INVERT_BRIGHTNESS)
                col[i] = 8'd255 - col[i];
            back[i] = c.first_layer ? c.background_color[8*i +: 8] : w[32 + 8*i +: 8];
        end
        t = (32'(c.transparency) * 32'd256) / 32'd255;
        inv_t = 32'd256 - t;
        if (!c.pixel_format)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (t != 0)
                    res[8*i +: 8] = 8'((inv_t * col[i] + t * back[i]) >> 8);
                else
                    res[8*i +: 8] = col[i];
            end
        end
        else
        begin
            d = (alpha * inv_t) / 32'd255;
            if (c.invert_alpha)
            begin
                wb = d;
                wc = 32'd256 - d;
            end
            else
            begin
                wc = d;
                wb = 32'd256 - d;
            end
            for (int i = 0; i < 3; i++)
            begin
                res[8*i +: 8] = 8'((wc * col[i] + wb * back[i]) >> 8);
            end
        end
        return res;
    endfunction

    task automatic report(input string what);
        fail_count++;
        if (fail_count <= PRINT_CAP)
            $display("MISMATCH @%0t: %s", $realtime, what);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shadow_cfg <= CFG_RESET_VALUES;
            expected_pixels.delete();
            pending <= 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    CFG_PIXEL_FORMAT: shadow_cfg.pixel_format <= cfg_wdata[0];
                    CFG_ALPHA_LAST:   shadow_cfg.alpha_last <= cfg_wdata[0];
                    CFG_BYTE_ORDER:   shadow_cfg.byte_order <= cfg_wdata[0];
                    CFG_INVERT_ALPHA: shadow_cfg.invert_alpha <= cfg_wdata[0];
                    CFG_FIRST_LAYER:  shadow_cfg.first_layer <= cfg_wdata[0];
                    CFG_BACKGROUND:   shadow_cfg.background_color <= cfg_wdata[23:0];
                    CFG_TRANSPARENCY: shadow_cfg.transparency <= cfg_wdata[7:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                expected_pixels.push_back(blend_pixel(shadow_cfg, s_tdata));
            if (m_tvalid && m_tready)
            begin
                if (expected_pixels.size() == 0)
                begin
                    report($sformatf("result word %06h with no pixel outstanding", m_tdata));
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    for (int i = 0; i < 3; i++)
                    begin
                        if (m_tdata[8*i +: 8] !== want[8*i +: 8])
                            report($sformatf("result %0d out_ch%0d: got %0d, expected %0d",
                                             checked, i + 1, m_tdata[8*i +: 8],
                                             want[8*i +: 8]));
                    end
                    checked++;
                end
            end
            if (drain_done && !drain_seen)
            begin
                drain_seen = 1'b1;
                foreach (expected_pixels[k])
                    report($sformatf("pixel result %06h never arrived", expected_pixels[k]));
            end
            pending <= expected_pixels.size();
        end
    end

endmodule

FILE: verif/tb_bitmap_pixel_alpha_blender.sv
// Testbench top for the bitmap pixel alpha blender: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_bitmap_pixel_alpha_blender;
    import bpab_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
    localparam int CYCLE_LIMIT = 100000;
    localparam int RANDOM_PHASES = 12;
    localparam int WORDS_PER_PHASE = 100;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [55:0]           s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [23:0]           m_tdata;
    logic                  drain_done = 1'b0;

    int fail_count;
    int pending;
    int checked;
    int src_idle_pct = 8;
    int sink_idle_pct = 8;
    int pixels_sent = 0;
    int settings_applied = 0;
    int cycle_count = 0;

    bitmap_pixel_alpha_blender dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    bpab_blend_checker blend_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .drain_done (drain_done),
        .fail_count (fail_count),
        .pending    (pending),
        .checked    (checked)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles with %0d results outstanding.",
                     cycle_count, pending);
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic cfg_t setting(input bit pf, input bit al, input bit bo, input bit ia,
                                     input bit fl, input logic [23:0] bg,
                                     input logic [7:0] tr);
        cfg_t c;
        c.pixel_format = pf;
        c.alpha_last = al;
        c.byte_order = bo;
        c.invert_alpha = ia;
        c.first_layer = fl;
        c.background_color = bg;
        c.transparency = tr;
        return c;
    endfunction

    function automatic logic [7:0] rand_byte();
        case ($urandom_range(9))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [55:0] random_word();
        logic [55:0] w;
        for (int i = 0; i < 7; i++)
        begin
            w[8*i +: 8] = rand_byte();
        end
        return w;
    endfunction

    function automatic cfg_t random_setting();
        logic [7:0]  tr;
        logic [23:0] bg;
        case ($urandom_range(5))
            0: tr = 8'd0;
            1: tr = 8'd1;
            2: tr = 8'd128;
            3: tr = 8'd254;
            4: tr = 8'd255;
            default: tr = 8'($urandom);
        endcase
        case ($urandom_range(3))
            0: bg = 24'h000000;
            1: bg = 24'hFFFFFF;
            default: bg = 24'($urandom);
        endcase
        return setting(1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)),
                       1'($urandom_range(1)), 1'($urandom_range(1)), bg, tr);
    endfunction

    // Tasks below are entered at a falling edge and return at a falling edge.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [23:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge clk);
    endtask

    task automatic apply_setting(input cfg_t c, input bit noisy);
        logic [23:0] junk;
        junk = noisy ? 24'($urandom) : 24'd0;
        write_reg(CFG_PIXEL_FORMAT, {junk[23:1], c.pixel_format});
        write_reg(CFG_ALPHA_LAST, {junk[22:0], c.alpha_last});
        write_reg(CFG_BYTE_ORDER, {junk[23:1], c.byte_order});
        write_reg(CFG_INVERT_ALPHA, {junk[22:0], c.invert_alpha});
        write_reg(CFG_FIRST_LAYER, {junk[23:1], c.first_layer});
        write_reg(CFG_BACKGROUND, c.background_color);
        write_reg(CFG_TRANSPARENCY, {junk[23:8], c.transparency});
        write_reg(CFG_UNUSED, 24'($urandom));
        cfg_wr_en <= 1'b0;
        @(negedge clk);
        settings_applied++;
    endtask

    task automatic push_pixel(input logic [55:0] w);
        while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= w;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pixels_sent++;
        @(negedge clk);
    endtask

    task automatic wait_results();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
    endtask

    task automatic settle();
        wait_results();
        repeat (8) @(negedge clk);
    endtask

    initial
    begin
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings: RGB with zero transparency copies the source; byte three is unused.
        push_pixel(56'h00_00_00_00_00_00_00);
        push_pixel(56'hFF_FF_FF_FF_FF_FF_FF);
        push_pixel(56'h77_66_55_A5_33_22_11);
        push_pixel(56'h88_99_AA_5A_33_22_11);

        settle();
        apply_setting(setting(1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 24'hFF8001, 8'd255), 1'b1);
        push_pixel(56'h00_00_00_00_00_00_00);
        push_pixel(56'hFF_FF_FF_FF_FF_FF_FF);
        push_pixel(56'h12_34_56_00_C0_80_40);

        settle();
        apply_setting(setting(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 24'h000000, 8'd1), 1'b0);
        push_pixel(56'hFF_FF_FF_00_00_00_00);
        push_pixel(56'h00_00_00_FF_FF_FF_FF);
        push_pixel(56'h80_40_C0_7F_10_F0_01);

        settle();
        apply_setting(setting(1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 24'hFFFFFF, 8'd0), 1'b1);
        push_pixel(56'h10_20_30_C0_80_40_00);
        push_pixel(56'h10_20_30_C0_80_40_FF);
        push_pixel(56'hFF_00_FF_01_FE_7F_80);

        settle();
        apply_setting(setting(1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 24'h000000, 8'd0), 1'b0);
        push_pixel(56'hFF_FF_FF_00_00_00_00);
        push_pixel(56'h00_00_00_FF_FF_FF_FF);
        push_pixel(56'h5A_A5_3C_C3_81_18_7E);

        settle();
        apply_setting(setting(1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 24'h3C5A96, 8'd255), 1'b1);
        push_pixel(56'h00_00_00_FF_FF_FF_FF);
        push_pixel(56'hFF_FF_FF_80_00_00_00);

        settle();
        apply_setting(setting(1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 24'h000000, 8'd128), 1'b0);
        push_pixel(56'h00_80_FF_00_FF_80_01);
        push_pixel(56'hFF_7F_00_FF_00_7F_FE);
        push_pixel(56'h11_22_33_80_44_55_66);

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            settle();
            src_idle_pct = (p == 4) ? 0 : 8;
            sink_idle_pct = (p == 4) ? 0 : 8;
            apply_setting(random_setting(), p[0]);
            for (int k = 0; k < WORDS_PER_PHASE; k++)
            begin
                if (p == 6 && k == WORDS_PER_PHASE / 2)
                    wait_results();
                push_pixel(random_word());
            end
        end

        settle();
        drain_done <= 1'b1;
        @(posedge clk);
        @(negedge clk);
        $display("Sent %0d pixels under %0d register settings; %0d blended results checked.",
                 pixels_sent, settings_applied + 1, checked);
        $display("Covered RGB and alpha pixels, both byte and alpha orders, %s",
                 "inverted alpha, first and later layers, and extreme transparency.");
        if (fail_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
